FILE: rtl/core/scancode_to_ascii_fifo_core_assert.svh
// Assertion macros for the keyboard FIFO core back end.
`ifndef SCANCODE_TO_ASCII_FIFO_CORE_ASSERT_SVH
`define SCANCODE_TO_ASCII_FIFO_CORE_ASSERT_SVH

// Checked at every clock edge outside reset.
`define SC2A_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SC2A_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/sc2a_pkg.sv
// Shared types, constants and character tables of the keyboard FIFO core.
package sc2a_pkg;

  localparam int CAPACITY_DEFAULT = 64;
  localparam int Q_DEPTH          = 2;
  localparam int FILL_W           = 6;

  localparam logic [7:0] KEY_LCTRL  = 8'd29;
  localparam logic [7:0] KEY_LSHIFT = 8'd42;
  localparam logic [7:0] REL_BIT    = 8'h80;
  localparam logic [7:0] KEY_C      = 8'h2E;
  localparam logic [7:0] KEY_R      = 8'h13;
  localparam logic [7:0] KEY_D      = 8'h20;
  localparam logic [7:0] EOF_BYTE   = 8'hFF;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH,
    OP_CLEAR,
    OP_SAVE,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
  } op_t;

  typedef enum logic {
    B_IDLE,
    B_LOOKUP
  } back_state_t;

  typedef struct packed {
    logic [6:0]        char_code;
    logic              char_valid;
    logic              end_of_file;
    logic              fifo_empty;
    logic              kill_request;
    logic              save_request;
    logic [FILL_W-1:0] fill_level;
  } result_t;

  function automatic logic [6:0] plain_char(input logic [6:0] lo);
    logic [6:0] c;
    case (lo)
      7'd2:  c = 7'h31;  7'd3:  c = 7'h32;  7'd4:  c = 7'h33;  7'd5:  c = 7'h34;
      7'd6:  c = 7'h35;  7'd7:  c = 7'h36;  7'd8:  c = 7'h37;  7'd9:  c = 7'h38;
      7'd10: c = 7'h39;  7'd11: c = 7'h30;  7'd12: c = 7'h2D;  7'd13: c = 7'h3D;
      7'd14: c = 7'h08;  7'd15: c = 7'h20;  7'd16: c = 7'h71;  7'd17: c = 7'h77;
      7'd18: c = 7'h65;  7'd19: c = 7'h72;  7'd20: c = 7'h74;  7'd21: c = 7'h79;
      7'd22: c = 7'h75;  7'd23: c = 7'h69;  7'd24: c = 7'h6F;  7'd25: c = 7'h70;
      7'd26: c = 7'h5B;  7'd27: c = 7'h5D;  7'd28: c = 7'h0A;  7'd30: c = 7'h61;
      7'd31: c = 7'h73;  7'd32: c = 7'h64;  7'd33: c = 7'h66;  7'd34: c = 7'h67;
      7'd35: c = 7'h68;  7'd36: c = 7'h6A;  7'd37: c = 7'h6B;  7'd38: c = 7'h6C;
      7'd39: c = 7'h3B;  7'd40: c = 7'h27;  7'd43: c = 7'h5C;  7'd44: c = 7'h7A;
      7'd45: c = 7'h78;  7'd46: c = 7'h63;  7'd47: c = 7'h76;  7'd48: c = 7'h62;
      7'd49: c = 7'h6E;  7'd50: c = 7'h6D;  7'd51: c = 7'h2C;  7'd52: c = 7'h2E;
      7'd53: c = 7'h2F;  7'd55: c = 7'h2A;  7'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] shift_char(input logic [6:0] lo);
    logic [6:0] c;
    case (lo)
      7'd2:  c = 7'h21;  7'd3:  c = 7'h40;  7'd4:  c = 7'h23;  7'd5:  c = 7'h24;
      7'd6:  c = 7'h25;  7'd7:  c = 7'h5E;  7'd8:  c = 7'h26;  7'd9:  c = 7'h2A;
      7'd10: c = 7'h28;  7'd11: c = 7'h29;  7'd12: c = 7'h5F;  7'd13: c = 7'h2B;
      7'd14: c = 7'h08;  7'd15: c = 7'h20;  7'd16: c = 7'h51;  7'd17: c = 7'h57;
      7'd18: c = 7'h45;  7'd19: c = 7'h52;  7'd20: c = 7'h54;  7'd21: c = 7'h59;
      7'd22: c = 7'h55;  7'd23: c = 7'h49;  7'd24: c = 7'h4F;  7'd25: c = 7'h50;
      7'd26: c = 7'h7B;  7'd27: c = 7'h7D;  7'd28: c = 7'h0A;  7'd30: c = 7'h41;
      7'd31: c = 7'h53;  7'd32: c = 7'h44;  7'd33: c = 7'h46;  7'd34: c = 7'h47;
      7'd35: c = 7'h48;  7'd36: c = 7'h4A;  7'd37: c = 7'h4B;  7'd38: c = 7'h4C;
      7'd39: c = 7'h3B;  7'd40: c = 7'h22;  7'd43: c = 7'h7C;  7'd44: c = 7'h5A;
      7'd45: c = 7'h58;  7'd46: c = 7'h43;  7'd47: c = 7'h56;  7'd48: c = 7'h42;
      7'd49: c = 7'h4E;  7'd50: c = 7'h4D;  7'd51: c = 7'h3C;  7'd52: c = 7'h3E;
      7'd53: c = 7'h3F;  7'd55: c = 7'h2A;  7'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/sc2a_front.sv
// Front end: accepts items, tracks ctrl and shift, and classifies each item into an operation.
module sc2a_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            cmd,
  input  logic [7:0]      scancode,
  input  logic            q_ready,
  output logic            op_valid,
  output sc2a_pkg::op_t   op
);

  logic ctrl_held;
  logic ctrl_held_next;
  logic shift_held;
  logic shift_held_next;
  logic accept;
  logic [7:0] stored_byte;

  assign in_ready    = q_ready;
  assign op_valid    = in_valid;
  assign accept      = in_valid && q_ready;
  assign stored_byte = shift_held ? (scancode | sc2a_pkg::REL_BIT) : scancode;

  always_comb begin
    ctrl_held_next  = ctrl_held;
    shift_held_next = shift_held;
    op.kind         = sc2a_pkg::OP_NONE;
    op.data         = stored_byte;
    if (cmd) begin
      op.kind = sc2a_pkg::OP_READ;
    end else if (scancode[7] == 1'b0) begin
      if (scancode == sc2a_pkg::KEY_LCTRL) begin
        ctrl_held_next = 1'b1;
      end else if (scancode == sc2a_pkg::KEY_LSHIFT) begin
        shift_held_next = 1'b1;
      end else if (ctrl_held) begin
        if (scancode == sc2a_pkg::KEY_C) begin
          op.kind = sc2a_pkg::OP_CLEAR;
        end else if (scancode == sc2a_pkg::KEY_R) begin
          op.kind = sc2a_pkg::OP_SAVE;
        end else if (scancode == sc2a_pkg::KEY_D) begin
          op.kind = sc2a_pkg::OP_PUSH;
          op.data = sc2a_pkg::EOF_BYTE;
        end
      end else if (sc2a_pkg::plain_char(scancode[6:0]) != 7'h00 ||
                   stored_byte == sc2a_pkg::EOF_BYTE) begin
        op.kind = sc2a_pkg::OP_PUSH;
      end
    end else begin
      if (scancode == (sc2a_pkg::KEY_LCTRL | sc2a_pkg::REL_BIT)) begin
        ctrl_held_next = 1'b0;
      end else if (scancode == (sc2a_pkg::KEY_LSHIFT | sc2a_pkg::REL_BIT)) begin
        shift_held_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_held  <= 1'b0;
      shift_held <= 1'b0;
    end else if (accept) begin
      ctrl_held  <= ctrl_held_next;
      shift_held <= shift_held_next;
    end
  end

endmodule

FILE: rtl/core/sc2a_queue.sv
// Short operation queue between the front end and the back end.
module sc2a_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sc2a_pkg::op_t in_op,
  output logic          out_valid,
  input  logic          out_ready,
  output sc2a_pkg::op_t out_op
);

  localparam int QAW = $clog2(sc2a_pkg::Q_DEPTH);

  sc2a_pkg::op_t entries [sc2a_pkg::Q_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   fill;
  logic push;
  logic pop;

  assign in_ready  = fill != (QAW + 1)'(sc2a_pkg::Q_DEPTH);
  assign out_valid = fill != '0;
  assign out_op    = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/sc2a_back.sv
// Back end: byte store, head and count, table lookup and the result register.
`include "scancode_to_ascii_fifo_core_assert.svh"

module sc2a_back #(
  parameter int CAPACITY = sc2a_pkg::CAPACITY_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  sc2a_pkg::op_t     q_op,
  output logic              out_valid,
  input  logic              out_ready,
  output sc2a_pkg::result_t res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;

  logic [7:0] mem [CAPACITY];
  logic [7:0] rd_data;
  logic [AW-1:0] wr_addr;
  logic mem_we;
  logic mem_re;

  sc2a_pkg::back_state_t state;
  sc2a_pkg::back_state_t state_next;
  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic out_valid_next;
  sc2a_pkg::result_t res_next;
  logic take;
  logic load;
  logic [SW-1:0] addr_sum;
  logic [CW+5:0] count_ext;

  assign take    = q_valid && state == sc2a_pkg::B_IDLE && (!out_valid || out_ready);
  assign q_ready = take;

  assign addr_sum = SW'(head) + SW'(count);
  assign wr_addr  = (addr_sum >= SW'(CAPACITY)) ? AW'(addr_sum - SW'(CAPACITY))
                                                : AW'(addr_sum);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= q_op.data;
    end
    if (mem_re) begin
      rd_data <= mem[head];
    end
  end

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    out_valid_next = out_valid && !out_ready;
    res_next       = res;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    load           = 1'b0;
    unique case (state)
      sc2a_pkg::B_IDLE: begin
        if (take) begin
          res_next = '0;
          load     = 1'b1;
          unique case (q_op.kind)
            sc2a_pkg::OP_PUSH: begin
              if (count < CW'(CAPACITY - 1)) begin
                mem_we     = 1'b1;
                count_next = count + 1'b1;
              end
            end
            sc2a_pkg::OP_CLEAR: begin
              head_next             = '0;
              count_next            = '0;
              res_next.kill_request = 1'b1;
            end
            sc2a_pkg::OP_SAVE: begin
              res_next.save_request = 1'b1;
            end
            sc2a_pkg::OP_READ: begin
              if (count == '0) begin
                res_next.fifo_empty = 1'b1;
              end else begin
                mem_re     = 1'b1;
                head_next  = (head == AW'(CAPACITY - 1)) ? '0 : head + 1'b1;
                count_next = count - 1'b1;
                load       = 1'b0;
                state_next = sc2a_pkg::B_LOOKUP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      sc2a_pkg::B_LOOKUP: begin
        res_next            = '0;
        load                = 1'b1;
        res_next.char_valid = 1'b1;
        if (rd_data == sc2a_pkg::EOF_BYTE) begin
          res_next.end_of_file = 1'b1;
        end else if (rd_data[7]) begin
          res_next.char_code = sc2a_pkg::shift_char(rd_data[6:0]);
        end else begin
          res_next.char_code = sc2a_pkg::plain_char(rd_data[6:0]);
        end
        state_next = sc2a_pkg::B_IDLE;
      end
      default: begin
        state_next = sc2a_pkg::B_IDLE;
      end
    endcase
    count_ext = (CW + 6)'(count_next);
    if (load) begin
      out_valid_next      = 1'b1;
      res_next.fill_level = count_ext[sc2a_pkg::FILL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sc2a_pkg::B_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  `SC2A_CHECK(a_count_bound, count <= CW'(CAPACITY - 1), "stored count above capacity")
  `SC2A_CHECK(a_lookup_free, state == sc2a_pkg::B_LOOKUP |-> !out_valid, "lookup with busy output")
  `SC2A_CHECK(a_clear_empties, (take && q_op.kind == sc2a_pkg::OP_CLEAR) |=> (count == '0 && head == '0), "clear left bytes")
  `SC2A_CHECK(a_read_lookup, (take && q_op.kind == sc2a_pkg::OP_READ && count != '0) |=> (state == sc2a_pkg::B_LOOKUP && !out_valid), "read did not start lookup")

endmodule

FILE: rtl/core/scancode_to_ascii_fifo_core.sv
// Top level of the keyboard scancode to ASCII FIFO core.
//
//   Channel  Handshake             Payload
//   -------  --------------------  ---------------------------------------------
//   input    in_valid, in_ready    cmd, scancode
//   output   out_valid, out_ready  char_code, char_valid, end_of_file,
//                                  fifo_empty, kill_request, save_request,
//                                  fill_level
//
// A key event or a read on an empty store is answered from the back end's idle state; a read
// that pops a byte also passes the lookup state, as the byte store has a registered read port.
// The front end and a two-entry operation queue accept a transaction per cycle while it has room.
// Reset is synchronous and clears the flags, queue, head, count and output valid.
// A stalled output holds the back end; the front end keeps filling the queue until it is full.
module scancode_to_ascii_fifo_core #(
  parameter int CAPACITY = sc2a_pkg::CAPACITY_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cmd,
  input  logic [7:0]                  scancode,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [6:0]                  char_code,
  output logic                        char_valid,
  output logic                        end_of_file,
  output logic                        fifo_empty,
  output logic                        kill_request,
  output logic                        save_request,
  output logic [sc2a_pkg::FILL_W-1:0] fill_level
);

  logic              q_in_ready;
  logic              op_valid;
  sc2a_pkg::op_t     op;
  logic              q_valid;
  logic              q_ready;
  sc2a_pkg::op_t     q_op;
  sc2a_pkg::result_t res;

  sc2a_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .scancode (scancode),
    .q_ready  (q_in_ready),
    .op_valid (op_valid),
    .op       (op)
  );

  sc2a_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (op_valid),
    .in_ready  (q_in_ready),
    .in_op     (op),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_op    (q_op)
  );

  sc2a_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_op      (q_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign char_code    = res.char_code;
  assign char_valid   = res.char_valid;
  assign end_of_file  = res.end_of_file;
  assign fifo_empty   = res.fifo_empty;
  assign kill_request = res.kill_request;
  assign save_request = res.save_request;
  assign fill_level   = res.fill_level;

endmodule

FILE: tb/sv/sc2a_tb_pkg.sv
// Command codes shared by the keyboard FIFO testbench modules.
`timescale 1ns / 100ps

package sc2a_tb_pkg;

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_READ = 1'b1;

endpackage

FILE: tb/sv/keyboard_fifo_scoreboard.sv
// Keyboard FIFO scoreboard: predicts each result from the accepted transactions and checks it.
`timescale 1ns / 100ps

module keyboard_fifo_scoreboard #(
  parameter int CAPACITY = sc2a_pkg::CAPACITY_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        cmd,
  input  logic [7:0]                  scancode,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [6:0]                  char_code,
  input  logic                        char_valid,
  input  logic                        end_of_file,
  input  logic                        fifo_empty,
  input  logic                        kill_request,
  input  logic                        save_request,
  input  logic [sc2a_pkg::FILL_W-1:0] fill_level,
  output int                          mismatches,
  output int                          outstanding,
  output int                          results_seen,
  output int                          eof_reads,
  output int                          empty_reads,
  output int                          kill_events,
  output int                          save_events
);

  import sc2a_pkg::*;
  import sc2a_tb_pkg::*;

  localparam int MAP_LEN = 58;

  logic [6:0] plain_ascii [MAP_LEN] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h20,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h00, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20
  };

  logic [6:0] shifted_ascii [MAP_LEN] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h20,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3B,
    7'h22, 7'h00, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20
  };

  logic [7:0] key_bytes [CAPACITY];
  int         head_pos;
  int         byte_count;
  bit         ctrl_down;
  bit         shift_down;
  result_t    expected_results [$];
  result_t    seen;
  result_t    want;

  function automatic void store_byte(input logic [7:0] b);
    bit mapped;
    mapped = (b[6:0] < MAP_LEN && plain_ascii[b[6:0]] != 7'h00) || b == EOF_BYTE;
    if (mapped && byte_count < CAPACITY) begin
      key_bytes[(head_pos + byte_count) % CAPACITY] = b;
      byte_count++;
    end
  endfunction

  function automatic result_t decode_item(input logic c, input logic [7:0] code);
    result_t    r;
    logic [7:0] b;
    r = '0;
    if (c == CMD_KEY) begin
      if ((code & REL_BIT) == 8'h00) begin
        if (code == KEY_LCTRL) begin
          ctrl_down = 1'b1;
        end else if (code == KEY_LSHIFT) begin
          shift_down = 1'b1;
        end else if (ctrl_down) begin
          if (code == KEY_C) begin
            head_pos   = 0;
            byte_count = 0;
            r.kill_request = 1'b1;
          end else if (code == KEY_R) begin
            r.save_request = 1'b1;
          end else if (code == KEY_D && byte_count < CAPACITY - 1) begin
            store_byte(EOF_BYTE);
          end
        end else if (byte_count < CAPACITY - 1) begin
          store_byte(shift_down ? (code | REL_BIT) : code);
        end
      end else if (code == (KEY_LCTRL | REL_BIT)) begin
        ctrl_down = 1'b0;
      end else if (code == (KEY_LSHIFT | REL_BIT)) begin
        shift_down = 1'b0;
      end
    end else if (byte_count == 0) begin
      r.fifo_empty = 1'b1;
    end else begin
      b = key_bytes[head_pos];
      head_pos = (head_pos + 1) % CAPACITY;
      byte_count--;
      r.char_valid = 1'b1;
      if (b == EOF_BYTE) begin
        r.end_of_file = 1'b1;
      end else if (b[6:0] < MAP_LEN) begin
        r.char_code = b[7] ? shifted_ascii[b[6:0]] : plain_ascii[b[6:0]];
      end
    end
    r.fill_level = byte_count[FILL_W-1:0];
    return r;
  endfunction

  function automatic void compare_field(input string field, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      head_pos   = 0;
      byte_count = 0;
      ctrl_down  = 1'b0;
      shift_down = 1'b0;
      expected_results.delete();
      outstanding = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen = {char_code, char_valid, end_of_file, fifo_empty, kill_request, save_request,
                fill_level};
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with no transaction waiting, expected none, got %h",
                   $time, seen);
        end else begin
          want = expected_results.pop_front();
          compare_field("char_code", want.char_code, seen.char_code);
          compare_field("char_valid", want.char_valid, seen.char_valid);
          compare_field("end_of_file", want.end_of_file, seen.end_of_file);
          compare_field("fifo_empty", want.fifo_empty, seen.fifo_empty);
          compare_field("kill_request", want.kill_request, seen.kill_request);
          compare_field("save_request", want.save_request, seen.save_request);
          compare_field("fill_level", want.fill_level, seen.fill_level);
          results_seen++;
          eof_reads   += want.end_of_file;
          empty_reads += want.fifo_empty;
          kill_events += want.kill_request;
          save_events += want.save_request;
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(decode_item(cmd, scancode));
      end
      outstanding = expected_results.size();
    end
  end

endmodule

FILE: tb/sv/scancode_to_ascii_fifo_core_tb.sv
// Testbench top for the keyboard FIFO core: clock, reset, stimulus, output pacing and verdict.
`timescale 1ns / 100ps

module scancode_to_ascii_fifo_core_tb;

  import sc2a_pkg::*;
  import sc2a_tb_pkg::*;

  localparam int RUN_ITEMS   = 1400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 150;
  localparam int IDLE_PCT    = 9;

  localparam logic [7:0] SC_ZERO     = 8'h00;
  localparam logic [7:0] SC_ONE      = 8'd2;
  localparam logic [7:0] SC_Q        = 8'd16;
  localparam logic [7:0] SC_A        = 8'd30;
  localparam logic [7:0] SC_SPACE    = 8'd57;
  localparam logic [7:0] SC_PAST_MAP = 8'd58;
  localparam logic [7:0] SC_TOP      = 8'h7F;
  localparam logic [7:0] SC_ALL_ONES = 8'hFF;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic                 cmd;
  logic [7:0]           scancode;
  logic                 out_valid;
  logic                 out_ready;
  logic [6:0]           char_code;
  logic                 char_valid;
  logic                 end_of_file;
  logic                 fifo_empty;
  logic                 kill_request;
  logic                 save_request;
  logic [FILL_W-1:0]    fill_level;

  int mismatches;
  int outstanding;
  int results_seen;
  int eof_reads;
  int empty_reads;
  int kill_events;
  int save_events;
  int items_sent  = 0;
  int cycle_count = 0;
  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_req;
  bit hold_done;

  scancode_to_ascii_fifo_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .scancode     (scancode),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .char_code    (char_code),
    .char_valid   (char_valid),
    .end_of_file  (end_of_file),
    .fifo_empty   (fifo_empty),
    .kill_request (kill_request),
    .save_request (save_request),
    .fill_level   (fill_level)
  );

  keyboard_fifo_scoreboard u_scoreboard (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .scancode     (scancode),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .char_code    (char_code),
    .char_valid   (char_valid),
    .end_of_file  (end_of_file),
    .fifo_empty   (fifo_empty),
    .kill_request (kill_request),
    .save_request (save_request),
    .fill_level   (fill_level),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .eof_reads    (eof_reads),
    .empty_reads  (empty_reads),
    .kill_events  (kill_events),
    .save_events  (save_events)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        out_ready <= !(rx_idle_en && $urandom_range(0, 99) < IDLE_PCT);
        @(negedge clk);
      end
    end
  end

  task automatic send_item(input logic c, input logic [7:0] code);
    if (tx_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    scancode <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic key(input logic [7:0] code);
    send_item(CMD_KEY, code);
  endtask

  task automatic read_char();
    send_item(CMD_READ, 8'($urandom_range(0, 255)));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      return 8'($urandom_range(1, 57));
    end else if (r < 95) begin
      return 8'($urandom_range(58, 127));
    end
    return SC_ZERO;
  endfunction

  task automatic random_sequence();
    int         kind;
    int         len;
    bit         shifted;
    logic [7:0] k;
    logic [7:0] combo [5];
    kind = $urandom_range(0, 99);
    len  = $urandom_range(1, 8);
    if (kind < 45) begin
      shifted = ($urandom_range(0, 99) < 30);
      if (shifted) key(KEY_LSHIFT);
      repeat (len) begin
        k = pick_key();
        key(k);
        if ($urandom_range(0, 1)) key(k | REL_BIT);
      end
      if (shifted) key(KEY_LSHIFT | REL_BIT);
    end else if (kind < 75) begin
      repeat (len) read_char();
    end else if (kind < 85) begin
      combo = '{KEY_C, KEY_R, KEY_D, KEY_D, pick_key()};
      key(KEY_LCTRL);
      key(combo[3'($urandom_range(0, 4))]);
      if ($urandom_range(0, 9) != 0) key(KEY_LCTRL | REL_BIT);
    end else begin
      repeat ($urandom_range(1, 4)) begin
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    cmd        = CMD_KEY;
    scancode   = SC_ZERO;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_req   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    read_char();
    key(SC_A);
    key(SC_ONE);
    key(SC_SPACE);
    key(SC_ZERO);
    key(SC_TOP);
    key(SC_PAST_MAP);
    key(KEY_LSHIFT);
    key(SC_TOP);
    key(SC_Q);
    key(KEY_LSHIFT | REL_BIT);
    key(KEY_LCTRL);
    key(KEY_D);
    key(KEY_R);
    key(SC_A);
    key(KEY_LCTRL | REL_BIT);
    key(REL_BIT);
    key(SC_ALL_ONES);
    repeat (7) read_char();
    key(SC_A);
    key(KEY_LCTRL);
    key(KEY_C);
    key(KEY_LCTRL | REL_BIT);
    read_char();

    // Stall the output for a long time while the FIFO is filled past its limit.
    hold_req = 1'b1;
    repeat (70) key(SC_A);
    key(KEY_LCTRL);
    key(KEY_D);
    key(KEY_LCTRL | REL_BIT);
    repeat (66) read_char();
    drain_results();

    while (items_sent < 700) random_sequence();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (items_sent < 1000) random_sequence();
    drain_results();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    while (items_sent < RUN_ITEMS) random_sequence();

    in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d transactions and checked %0d results in %0d cycles.",
             items_sent, results_seen, cycle_count);
    $display("Seen: %0d end-of-file reads, %0d empty reads, %0d kills, %0d saves.",
             eof_reads, empty_reads, kill_events, save_events);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: scancode_to_ascii_fifo_core.f
+incdir+rtl/core
rtl/core/sc2a_pkg.sv
rtl/core/sc2a_front.sv
rtl/core/sc2a_queue.sv
rtl/core/sc2a_back.sv
rtl/core/scancode_to_ascii_fifo_core.sv
tb/sv/sc2a_tb_pkg.sv
tb/sv/keyboard_fifo_scoreboard.sv
tb/sv/scancode_to_ascii_fifo_core_tb.sv
